// ----- rtl/core/pbld_pkg.sv -----
// ----------------------------------------------------------------------------
// pbld_pkg
// Shared types and constants of the page band line drawer: command codes,
// buffer operations and the control links between controller and datapath.
// ----------------------------------------------------------------------------
package pbld_pkg;

    localparam logic [2:0] KIND_SET_ROW    = 3'd0;
    localparam logic [2:0] KIND_CLEAR_ROW  = 3'd1;
    localparam logic [2:0] KIND_INVERT_ROW = 3'd2;
    localparam logic [2:0] KIND_SET_COL    = 3'd3;
    localparam logic [2:0] KIND_INVERT_COL = 3'd4;
    localparam logic [2:0] KIND_CLEAR_BAND = 3'd5;
    localparam logic [2:0] KIND_READ_COL   = 3'd6;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [2:0] BIT_MAX   = 3'd7;

    // Operation applied to each column byte that a command walks over.
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_CLR  = 2'd1,
        OP_XOR  = 2'd2,
        OP_READ = 2'd3
    } pbld_op_t;

    typedef struct packed {
        logic load;      // capture the accepted command
        logic rd_issue;  // read the column under the read pointer
        logic emit;      // move the finished result to the output register
    } pbld_cmd_t;

    typedef struct packed {
        logic need_mem;  // the offered command touches the buffer
        logic rd_last;   // the read pointer is at the last column
    } pbld_sts_t;

endpackage

// ----- rtl/core/pbld_ram.sv -----
// ----------------------------------------------------------------------------
// pbld_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pbld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/pbld_datapath.sv -----
// ----------------------------------------------------------------------------
// pbld_datapath
// Command decode, column pointer, read-modify-write path into the page
// buffer, per-column valid bits and the result registers.
// ----------------------------------------------------------------------------
module pbld_datapath #(
    parameter int COLUMNS = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbld_pkg::pbld_cmd_t cmd,
    output pbld_pkg::pbld_sts_t sts,
    input  logic [2:0]          s_kind,
    input  logic [7:0]          s_x_start,
    input  logic [7:0]          s_x_end,
    input  logic [7:0]          s_row_start,
    input  logic [7:0]          s_row_end,
    input  logic                cfg_wr_en,
    input  logic [5:0]          cfg_wr_data,
    output logic [7:0]          m_column_data
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [8:0] LAST_COL = 9'(COLUMNS - 1);

    logic [5:0]         band_top_reg;
    pbld_pkg::pbld_op_t op_reg, op_next;
    logic [7:0]         mask_reg, mask_next;
    logic [CW-1:0]      xb_reg, xb_next;
    logic [CW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      pend_addr_reg;
    logic               pend_reg;
    logic [COLUMNS-1:0] valid_reg;
    logic [7:0]         res_reg;
    logic [7:0]         out_data_reg;

    logic [CW-1:0] xa_clamp, xe_clamp;
    logic [8:0]    bottom, top9, r0_9, r1_9;
    logic          row_in_band, col_hit;
    logic [7:0]    start_mask, end_mask;
    logic [2:0]    end_shift;
    logic          need_mem;
    logic [7:0]    ram_rdata, cur_byte, new_byte;
    logic          ram_we;

    // Column clamp to the last buffer column.
    assign xa_clamp = ({1'b0, s_x_start} > LAST_COL) ? LAST_COL[CW-1:0] : s_x_start[CW-1:0];
    assign xe_clamp = ({1'b0, s_x_end} > LAST_COL) ? LAST_COL[CW-1:0] : s_x_end[CW-1:0];

    assign top9   = {3'b000, band_top_reg};
    assign bottom = top9 + 9'd8;
    assign r0_9   = {1'b0, s_row_start};
    assign r1_9   = {1'b0, s_row_end};

    assign row_in_band = (r0_9 >= top9) && (r0_9 < bottom);
    assign col_hit     = (r0_9 < bottom) && (r1_9 >= top9);

    // The low three bits of band_top + 7 - row_end are exact when the end row
    // lies inside the band, which is the only time the shift is used.
    assign end_shift  = band_top_reg[2:0] + pbld_pkg::BIT_MAX - s_row_end[2:0];
    assign start_mask = (r0_9 < top9) ? pbld_pkg::BYTE_ONES
                                      : (pbld_pkg::BYTE_ONES << s_row_start[2:0]);
    assign end_mask   = (r1_9 < bottom) ? (pbld_pkg::BYTE_ONES >> end_shift)
                                        : pbld_pkg::BYTE_ONES;

    always_comb begin
        op_next   = pbld_pkg::OP_READ;
        mask_next = 8'(1) << s_row_start[2:0];
        xb_next   = xa_clamp;
        need_mem  = 1'b0;
        unique case (s_kind)
            pbld_pkg::KIND_SET_ROW: begin
                op_next  = pbld_pkg::OP_SET;
                xb_next  = xe_clamp;
                need_mem = (xa_clamp <= xe_clamp) && row_in_band;
            end
            pbld_pkg::KIND_CLEAR_ROW: begin
                op_next  = pbld_pkg::OP_CLR;
                xb_next  = xe_clamp;
                need_mem = (xa_clamp <= xe_clamp) && row_in_band;
            end
            pbld_pkg::KIND_INVERT_ROW: begin
                op_next  = pbld_pkg::OP_XOR;
                xb_next  = xe_clamp;
                need_mem = (xa_clamp <= xe_clamp) && row_in_band;
            end
            pbld_pkg::KIND_SET_COL: begin
                op_next   = pbld_pkg::OP_SET;
                mask_next = start_mask & end_mask;
                need_mem  = col_hit;
            end
            pbld_pkg::KIND_INVERT_COL: begin
                op_next   = pbld_pkg::OP_XOR;
                mask_next = start_mask & end_mask;
                need_mem  = col_hit;
            end
            pbld_pkg::KIND_READ_COL: begin
                op_next  = pbld_pkg::OP_READ;
                need_mem = 1'b1;
            end
            default: begin
                need_mem = 1'b0;
            end
        endcase
    end

    assign sts.need_mem = need_mem;
    assign sts.rd_last  = (rd_ptr_reg == xb_reg);

    // An entry that has not been written since reset or a band clear reads
    // as zero.
    assign cur_byte = valid_reg[pend_addr_reg] ? ram_rdata : 8'h00;

    always_comb begin
        unique case (op_reg)
            pbld_pkg::OP_SET:  new_byte = cur_byte | mask_reg;
            pbld_pkg::OP_CLR:  new_byte = cur_byte & ~mask_reg;
            pbld_pkg::OP_XOR:  new_byte = cur_byte ^ mask_reg;
            pbld_pkg::OP_READ: new_byte = cur_byte;
            default:           new_byte = cur_byte;
        endcase
    end

    assign ram_we = pend_reg && (op_reg != pbld_pkg::OP_READ);

    pbld_ram #(
        .WIDTH (8),
        .DEPTH (COLUMNS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pend_addr_reg),
        .wdata (new_byte),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_top_reg <= 6'd0;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                band_top_reg <= cfg_wr_data;
            end
            pend_reg <= cmd.rd_issue;
            if (cmd.load && (s_kind == pbld_pkg::KIND_CLEAR_BAND)) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[pend_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_next;
            mask_reg   <= mask_next;
            xb_reg     <= xb_next;
            rd_ptr_reg <= xa_clamp;
            res_reg    <= 8'h00;
        end else begin
            if (cmd.rd_issue) begin
                rd_ptr_reg <= rd_ptr_reg + CW'(1);
            end
            if (pend_reg && (op_reg == pbld_pkg::OP_READ)) begin
                res_reg <= cur_byte;
            end
        end
        if (cmd.rd_issue) begin
            pend_addr_reg <= rd_ptr_reg;
        end
        if (cmd.emit) begin
            out_data_reg <= res_reg;
        end
    end

    assign m_column_data = out_data_reg;

    // A buffer write always follows a read issued in the previous cycle.
    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(cmd.rd_issue))
        else $error("buffer write without a preceding read");

    // A band clear leaves every column reading as zero.
    a_clear_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && (s_kind == pbld_pkg::KIND_CLEAR_BAND)) |=> (valid_reg == '0))
        else $error("band clear left valid columns");

    // The read pointer never passes the last column of the run while reading.
    a_ptr_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (rd_ptr_reg <= xb_reg))
        else $error("read pointer beyond the end of the run");

endmodule

// ----- rtl/core/pbld_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbld_ctrl
// Sequencer of the page band line drawer: accepts a command, steps the
// column reads, drains the last write and hands the result to the output.
// ----------------------------------------------------------------------------
module pbld_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pbld_pkg::pbld_sts_t sts,
    output pbld_pkg::pbld_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.need_mem ? S_READ : S_FIN;
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                if (sts.rd_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                // A previous result may still be waiting at the output.
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ((state_reg == S_READ) || (state_reg == S_FIN)))
        else $error("accepted command did not start");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside the finish step");

    a_drain_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN) |-> ($past(state_reg) == S_READ))
        else $error("drain step not preceded by a read step");

endmodule

// ----- rtl/core/page_band_line_drawer_top.sv -----
// ----------------------------------------------------------------------------
// page_band_line_drawer_top
// One 8-row page band of a monochrome display, one byte per column, with
// row, column-run, clear and read commands.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  s_        in         s_valid / s_ready     kind, x_start, x_end, row_start, row_end
//  m_        out        m_valid / m_ready     column_data
//  cfg_      in         cfg_wr_en             cfg_wr_data (band_top)
//
//  A row run inside the band over n >= 1 columns reads one column per cycle
//  with the write trailing, then drains the last write and finishes; column
//  runs that reach the band and reads do so for one column, others just finish.
//  Reset clears the per-column valid bits at once, so no clearing pass runs.
//  One command is in work at a time; a new one is taken while a result
//  still waits at the output register, and its result waits for that slot.
// ----------------------------------------------------------------------------
module page_band_line_drawer_top #(
    parameter int COLUMNS = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  logic [7:0] s_x_start,
    input  logic [7:0] s_x_end,
    input  logic [7:0] s_row_start,
    input  logic [7:0] s_row_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_column_data,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data
);

    pbld_pkg::pbld_cmd_t cmd;
    pbld_pkg::pbld_sts_t sts;

    pbld_datapath #(
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_kind        (s_kind),
        .s_x_start     (s_x_start),
        .s_x_end       (s_x_end),
        .s_row_start   (s_row_start),
        .s_row_end     (s_row_end),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_column_data (m_column_data)
    );

    pbld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

endmodule
